@@ hdl/drs_pkg.sv @@
package drs_pkg;

    // Window depth default and fixed field widths
    localparam int DRS_WINDOW   = 16;
    localparam int DRS_MIN_FILL = 5;
    localparam int TIME_W       = 16;
    localparam int DIM_W        = 16;
    localparam int RDIM_W       = 18;
    localparam int SCALE_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SCALE_W-1:0] ONE_Q15 = 16'd32768;

    // Opcodes
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY  = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_HIGH_THR  = 16'd4693;
    localparam logic [15:0] RST_LOW_THR   = 16'd3840;
    localparam logic [15:0] RST_MIN_SCALE = 16'd16384;
    localparam logic [15:0] RST_MAX_SCALE = 16'd32768;
    localparam logic [15:0] RST_DECAY     = 16'd1638;
    localparam logic [15:0] RST_RECOVERY  = 16'd655;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] frame_time;
        logic [DIM_W-1:0]  native_width;
        logic [DIM_W-1:0]  native_height;
    } t_in_req;

    typedef struct packed {
        logic [RDIM_W-1:0]  render_width;
        logic [RDIM_W-1:0]  render_height;
        logic [SCALE_W-1:0] scale_now;
    } t_out_rsp;

endpackage

@@ hdl/dynamic_resolution_scaler.sv @@
// Path: an accepted request passes the stage 1, 2 and 3 registers, then the result queue.
// Throughput: one request per cycle unless the result queue is full; window memory read at
// accept, written one stage later; sum and scale registers each update once per cycle.
// A two-entry result queue lets requests enter while a result waits to be taken.
// Reset: synchronous, active low; registers take their defaults, pointer, fill count and
// sum are cleared, scale goes to ONE_Q15; window memory is not cleared, fill count guards it.
module dynamic_resolution_scaler #(
    parameter int WINDOW = drs_pkg::DRS_WINDOW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  drs_pkg::t_in_req                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output drs_pkg::t_out_rsp               o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [drs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import drs_pkg::*;

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = TIME_W + $clog2(WINDOW);
    localparam int PROD_W = TIME_W + FILL_W;
    localparam int MUL_W  = DIM_W + SCALE_W;

    // Configuration registers
    logic               r_en;
    logic [15:0]        r_hi_thr, r_lo_thr, r_min, r_max, r_decay, r_recov;
    logic               w_cfg_wr, w_en_flip;

    // Window state
    logic [TIME_W-1:0]  r_win [WINDOW];
    logic [TIME_W-1:0]  r_rd;
    logic [PTR_W-1:0]   r_ptr;
    logic [FILL_W-1:0]  r_fill;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SCALE_W-1:0] r_scale, n_scale;

    // Flow control
    logic               w_adv, w_acc, w_push, w_pop, w_tail;

    // Stage 1 (memory read data valid)
    logic               r_s1_vld, r_s1_frame, r_s1_query, r_s1_clear, r_s1_drop;
    logic [PTR_W-1:0]   r_s1_addr;
    logic [FILL_W-1:0]  r_s1_fill;
    logic [TIME_W-1:0]  r_s1_ft;
    logic [DIM_W-1:0]   r_s1_nw, r_s1_nh;

    // Stage 2 (threshold compare, scale update)
    logic               r_s2_vld, r_s2_chk, r_s2_query, r_s2_clear;
    logic [SUM_W-1:0]   r_s2_sum;
    logic [PROD_W-1:0]  r_s2_phi, r_s2_plo;
    logic [DIM_W-1:0]   r_s2_nw, r_s2_nh;

    // Stage 3 (rounding)
    logic               r_s3_vld, r_s3_query;
    logic [MUL_W-1:0]   r_s3_pw, r_s3_ph;
    logic [DIM_W-1:0]   r_s3_nw, r_s3_nh;
    logic [SCALE_W-1:0] r_s3_scale;
    t_out_rsp           w_res;

    // Result queue
    t_out_rsp           r_q [2];
    logic               r_qhead;
    logic [1:0]         r_qcnt;

    // Handshakes
    assign w_adv       = (r_qcnt != 2'd2);
    assign o_in_stall  = !w_adv;
    assign w_acc       = i_in_valid && w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_en_flip   = w_cfg_wr && (i_cfg_index == REG_ENABLE) && (i_cfg_data[0] != r_en);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_hi_thr <= RST_HIGH_THR;
            r_lo_thr <= RST_LOW_THR;
            r_min    <= RST_MIN_SCALE;
            r_max    <= RST_MAX_SCALE;
            r_decay  <= RST_DECAY;
            r_recov  <= RST_RECOVERY;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                REG_ENABLE:    r_en     <= i_cfg_data[0];
                REG_HIGH_THR:  r_hi_thr <= i_cfg_data;
                REG_LOW_THR:   r_lo_thr <= i_cfg_data;
                REG_MIN_SCALE: r_min    <= i_cfg_data;
                REG_MAX_SCALE: r_max    <= i_cfg_data;
                REG_DECAY:     r_decay  <= i_cfg_data;
                REG_RECOVERY:  r_recov  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window memory: read oldest entry at accept, write new sample one stage later
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_vld && r_s1_frame) begin
            r_win[r_s1_addr] <= r_s1_ft;
        end
        if (w_acc) begin
            r_rd <= r_win[r_ptr];
        end
    end

    // Accept stage: pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_fill   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_vld <= w_acc;
            end
            if (w_acc) begin
                if (i_in_data.opcode == OP_CLEAR) begin
                    r_ptr  <= '0;
                    r_fill <= '0;
                end else if (i_in_data.opcode == OP_FRAME && r_en) begin
                    r_ptr <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                    if (r_fill != FILL_W'(WINDOW)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
            if (w_en_flip) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_frame <= (i_in_data.opcode == OP_FRAME) && r_en;
            r_s1_query <= (i_in_data.opcode == OP_QUERY);
            r_s1_clear <= (i_in_data.opcode == OP_CLEAR);
            r_s1_drop  <= (r_fill == FILL_W'(WINDOW));
            r_s1_addr  <= r_ptr;
            r_s1_fill  <= (r_fill == FILL_W'(WINDOW)) ? r_fill : r_fill + 1'b1;
            r_s1_ft    <= i_in_data.frame_time;
            r_s1_nw    <= i_in_data.native_width;
            r_s1_nh    <= i_in_data.native_height;
        end
    end

    // Running sum: drop oldest when full, add new sample
    always_comb begin
        n_sum = r_sum + SUM_W'(r_s1_ft);
        if (r_s1_drop) begin
            n_sum = n_sum - SUM_W'(r_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s2_vld <= r_s1_vld;
                if (r_s1_vld && r_s1_clear) begin
                    r_sum <= '0;
                end else if (r_s1_vld && r_s1_frame) begin
                    r_sum <= n_sum;
                end
            end
            if (w_en_flip) begin
                r_sum <= '0;
            end
        end
    end

    // Stage 2 payload: sum snapshot and threshold products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_chk   <= r_s1_frame && (r_s1_fill >= FILL_W'(DRS_MIN_FILL));
            r_s2_query <= r_s1_query;
            r_s2_clear <= r_s1_clear;
            r_s2_sum   <= n_sum;
            r_s2_phi   <= PROD_W'(r_hi_thr) * PROD_W'(r_s1_fill);
            r_s2_plo   <= PROD_W'(r_lo_thr) * PROD_W'(r_s1_fill);
            r_s2_nw    <= r_s1_nw;
            r_s2_nh    <= r_s1_nh;
        end
    end

    // Scale step with hysteresis; stepping down wins
    always_comb begin
        logic [SCALE_W:0] v_dn;
        logic [SCALE_W:0] v_up;
        v_dn    = {1'b0, r_scale} - {1'b0, r_decay};
        v_up    = {1'b0, r_scale} + {1'b0, r_recov};
        n_scale = r_scale;
        if (r_s2_clear) begin
            n_scale = ONE_Q15;
        end else if (r_s2_chk) begin
            if (PROD_W'(r_s2_sum) > r_s2_phi) begin
                n_scale = (v_dn[SCALE_W] || (v_dn[SCALE_W-1:0] < r_min)) ?
                          r_min : v_dn[SCALE_W-1:0];
            end else if ((PROD_W'(r_s2_sum) < r_s2_plo) && (r_scale < r_max)) begin
                n_scale = (v_up > {1'b0, r_max}) ? r_max : v_up[SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= ONE_Q15;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s3_vld <= r_s2_vld;
                if (r_s2_vld) begin
                    r_scale <= n_scale;
                end
            end
            if (w_en_flip) begin
                r_scale <= ONE_Q15;
            end
        end
    end

    // Stage 3 payload: size products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_query <= r_s2_query;
            r_s3_pw    <= MUL_W'(r_s2_nw) * MUL_W'(r_scale);
            r_s3_ph    <= MUL_W'(r_s2_nh) * MUL_W'(r_scale);
            r_s3_nw    <= r_s2_nw;
            r_s3_nh    <= r_s2_nh;
            r_s3_scale <= n_scale;
        end
    end

    // Round up to a multiple of eight, floor of eight
    function automatic logic [RDIM_W-1:0] round_dim(input logic [MUL_W-1:0] prod);
        logic [RDIM_W-1:0] v;
        v = {1'b0, prod[MUL_W-1:SCALE_W-1]} + RDIM_W'(7);
        v = {v[RDIM_W-1:3], 3'b000};
        if (v < RDIM_W'(8)) begin
            v = RDIM_W'(8);
        end
        return v;
    endfunction

    always_comb begin
        w_res.render_width  = '0;
        w_res.render_height = '0;
        w_res.scale_now     = r_s3_scale;
        if (r_s3_query) begin
            if (r_en) begin
                w_res.render_width  = round_dim(r_s3_pw);
                w_res.render_height = round_dim(r_s3_ph);
            end else begin
                w_res.render_width  = RDIM_W'(r_s3_nw);
                w_res.render_height = RDIM_W'(r_s3_nh);
            end
        end
    end

    // Two-entry result queue
    assign w_push      = w_adv && r_s3_vld;
    assign w_pop       = (r_qcnt != 2'd0) && !i_out_stall;
    assign w_tail      = r_qhead ^ (r_qcnt == 2'd1);
    assign o_out_valid = (r_qcnt != 2'd0);
    assign o_out_data  = r_q[r_qhead];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[w_tail] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qhead <= 1'b0;
            r_qcnt  <= 2'd0;
        end else begin
            r_qhead <= r_qhead ^ w_pop;
            r_qcnt  <= r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`ifndef SYNTHESIS
    a_clear_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.opcode == OP_CLEAR) |=> (r_ptr == '0 && r_fill == '0))
        else $error("clear request did not reset window pointer and fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill count beyond window depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WINDOW - 1))
        else $error("write pointer beyond window depth");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcnt == 2'd2) |=> (r_qcnt != 2'd3))
        else $error("result queue overflow");
`endif

endmodule

@@ dv/tb_dynamic_resolution_scaler.sv @@
`timescale 1ns / 1ps

module tb_dynamic_resolution_scaler;
    import drs_pkg::*;

    // Opcode and register index outside the defined sets
    localparam logic [1:0]           OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;
    localparam int QUIET_LIMIT = 1000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_req               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_rsp              o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    dynamic_resolution_scaler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow registers and controller state of the scaler
    logic              cfg_en  = 1'b0;
    logic [15:0]       cfg_hi  = RST_HIGH_THR;
    logic [15:0]       cfg_lo  = RST_LOW_THR;
    logic [15:0]       cfg_min = RST_MIN_SCALE;
    logic [15:0]       cfg_max = RST_MAX_SCALE;
    logic [15:0]       cfg_dec = RST_DECAY;
    logic [15:0]       cfg_rec = RST_RECOVERY;
    logic [15:0]       win [DRS_WINDOW];
    logic [3:0]        wr;
    logic [4:0]        fill;
    logic [19:0]       sum;
    logic [15:0]       scale_val;

    t_out_rsp render_q [$];
    int  n_sent      = 0;
    int  n_done      = 0;
    int  err_cnt     = 0;
    int  quiet       = 0;
    int  stall_left  = 0;
    bit  idle_on     = 1'b1;

    function automatic void clear_window();
        foreach (win[k]) win[k] = '0;
        wr        = '0;
        fill      = '0;
        sum       = '0;
        scale_val = ONE_Q15;
    endfunction

    // Scale one dimension, round up to a multiple of 8, floor of 8
    function automatic logic [RDIM_W-1:0] scaled_dim(logic [15:0] native);
        logic [31:0] v;
        v = (32'(native) * 32'(scale_val)) >> 15;
        v = (v + 32'd7) & ~32'd7;
        if (v < 32'd8) v = 32'd8;
        return v[RDIM_W-1:0];
    endfunction

    // Advance the controller by one request and return its answer
    function automatic t_out_rsp scaler_step(t_in_req r);
        t_out_rsp rsp;
        int       n;
        longint   lim_hi;
        longint   lim_lo;
        rsp = '0;
        case (r.opcode)
            OP_FRAME: begin
                if (cfg_en) begin
                    if (fill == 5'(DRS_WINDOW)) sum = sum - 20'(win[wr]);
                    win[wr] = r.frame_time;
                    sum     = sum + 20'(r.frame_time);
                    wr      = wr + 4'd1;
                    if (fill < 5'(DRS_WINDOW)) fill = fill + 5'd1;
                    if (fill >= 5'(DRS_MIN_FILL)) begin
                        lim_hi = cfg_hi * fill;
                        lim_lo = cfg_lo * fill;
                        if (longint'(sum) > lim_hi) begin
                            // too slow: step down, floored at the minimum
                            n = int'(scale_val) - int'(cfg_dec);
                            if (n < int'(cfg_min)) n = int'(cfg_min);
                            scale_val = n[15:0];
                        end else if (longint'(sum) < lim_lo && scale_val < cfg_max) begin
                            n = int'(scale_val) + int'(cfg_rec);
                            if (n > int'(cfg_max)) n = int'(cfg_max);
                            scale_val = n[15:0];
                        end
                    end
                end
            end
            OP_QUERY: begin
                if (cfg_en) begin
                    rsp.render_width  = scaled_dim(r.native_width);
                    rsp.render_height = scaled_dim(r.native_height);
                end else begin
                    rsp.render_width  = RDIM_W'(r.native_width);
                    rsp.render_height = RDIM_W'(r.native_height);
                end
            end
            OP_CLEAR: begin
                clear_window();
            end
            default: ;
        endcase
        rsp.scale_now = scale_val;
        return rsp;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_cnt++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Observe handshakes: check results, track register writes, predict requests
    always @(posedge i_clk) begin
        t_out_rsp want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                n_done++;
                if (render_q.size() == 0) begin
                    err_cnt++;
                    $error("result with no request outstanding");
                end else begin
                    want = render_q.pop_front();
                    check_field("render_width", want.render_width, o_out_data.render_width);
                    check_field("render_height", want.render_height,
                                o_out_data.render_height);
                    check_field("scale_now", want.scale_now, o_out_data.scale_now);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    REG_ENABLE: begin
                        if (i_cfg_data[0] != cfg_en) begin
                            cfg_en = i_cfg_data[0];
                            clear_window();
                        end
                    end
                    REG_HIGH_THR:  cfg_hi  = i_cfg_data;
                    REG_LOW_THR:   cfg_lo  = i_cfg_data;
                    REG_MIN_SCALE: cfg_min = i_cfg_data;
                    REG_MAX_SCALE: cfg_max = i_cfg_data;
                    REG_DECAY:     cfg_dec = i_cfg_data;
                    REG_RECOVERY:  cfg_rec = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                render_q.push_back(scaler_step(i_in_data));
            end
            // watchdog on cycles with no handshake at all
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("dynamic_resolution_scaler verification failed");
                $finish;
            end
        end
    end

    // Result-side backpressure in random bursts, only while idle_on is set
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_in_req mk_req(logic [1:0] op, logic [15:0] ft,
                                       logic [15:0] w, logic [15:0] h);
        t_in_req r;
        r.opcode        = op;
        r.frame_time    = ft;
        r.native_width  = w;
        r.native_height = h;
        return r;
    endfunction

    // Hold a request until taken; valid stays high for a following request unless an idle gap is inserted
    task automatic send_req(t_in_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (n_done < n_sent) @(posedge i_clk);
    endtask

    // Valid stays high across back-to-back writes; caller lowers it
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic cfg_all(logic en, logic [15:0] hi, logic [15:0] lo, logic [15:0] mn,
                           logic [15:0] mx, logic [15:0] dec, logic [15:0] rec);
        cfg_write(REG_HIGH_THR, hi);
        cfg_write(REG_LOW_THR, lo);
        cfg_write(REG_MIN_SCALE, mn);
        cfg_write(REG_MAX_SCALE, mx);
        cfg_write(REG_DECAY, dec);
        cfg_write(REG_RECOVERY, rec);
        cfg_write(REG_ENABLE, {15'd0, en});
        i_cfg_valid <= 1'b0;
    endtask

    // Disabled: queries pass native sizes, frames and unused opcodes are ignored
    task automatic test_disabled_passthrough();
        send_req(mk_req(OP_QUERY, 16'd0, 16'd0, 16'd0));
        send_req(mk_req(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(OP_FRAME, 16'hFFFF, 16'h1234, 16'h5678));
        send_req(mk_req(OP_UNUSED, 16'hA5A5, 16'h5A5A, 16'hFFFF));
        wait_idle();
    endtask

    // Default registers: fill threshold, step down, query rounding, clear
    task automatic test_default_stepping();
        cfg_write(REG_ENABLE, 16'd1);
        i_cfg_valid <= 1'b0;
        repeat (5) send_req(mk_req(OP_FRAME, 16'hFFFF, 16'd0, 16'd0));
        send_req(mk_req(OP_QUERY, 16'd0, 16'd0, 16'd1));
        send_req(mk_req(OP_QUERY, 16'd0, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        wait_idle();
    endtask

    // Register extremes: crossed thresholds, step below the minimum, zero caps, enable writes
    task automatic test_register_extremes();
        cfg_all(1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (5) send_req(mk_req(OP_FRAME, 16'd1, 16'd0, 16'd0));
        send_req(mk_req(OP_QUERY, 16'd0, 16'hFFFF, 16'hFFFF));
        wait_idle();
        cfg_write(REG_MIN_SCALE, 16'd0);
        i_cfg_valid <= 1'b0;
        send_req(mk_req(OP_FRAME, 16'd1, 16'd0, 16'd0));
        send_req(mk_req(OP_QUERY, 16'd0, 16'hFFFF, 16'hFFFF));
        wait_idle();
        cfg_write(REG_MAX_SCALE, 16'd0);
        cfg_write(REG_HIGH_THR, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_req(mk_req(OP_FRAME, 16'd0, 16'd0, 16'd0));
        wait_idle();
        // unknown index ignored, same enable keeps state, disable clears
        cfg_write(REG_NONE, 16'hFFFF);
        cfg_write(REG_ENABLE, 16'hFFFF);
        cfg_write(REG_ENABLE, 16'hFFFE);
        i_cfg_valid <= 1'b0;
        send_req(mk_req(OP_QUERY, 16'd0, 16'h8001, 16'h7FFE));
        wait_idle();
        cfg_write(REG_ENABLE, 16'd1);
        i_cfg_valid <= 1'b0;
        send_req(mk_req(OP_QUERY, 16'd0, 16'd1, 16'hFFFF));
        wait_idle();
    endtask

    // Frame times clustered around the thresholds so the scale keeps moving
    function automatic logic [15:0] pick_frame_time();
        int v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            v = int'(cfg_hi) + int'($urandom_range(0, 1024)) - 512;
        else if (pick < 70)
            v = int'(cfg_lo) + int'($urandom_range(0, 1024)) - 512;
        else if (pick < 85)
            v = $urandom_range(0, 65535);
        else if (pick < 92)
            v = 0;
        else
            v = 65535;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 16'($urandom_range(0, 65535));
        if (pick < 75) return 16'($urandom_range(0, 16));
        if (pick < 90) return 16'hFFFF;
        return 16'($urandom_range(600, 4096));
    endfunction

    function automatic t_in_req pick_req();
        int          pick;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 68)      op = OP_FRAME;
        else if (pick < 95) op = OP_QUERY;
        else if (pick < 98) op = OP_CLEAR;
        else                op = OP_UNUSED;
        return mk_req(op, pick_frame_time(), pick_dim(), pick_dim());
    endfunction

    // Random phases, each with its own register setting
    task automatic test_random_load();
        int          mode;
        logic        en;
        logic [15:0] lo;
        logic [15:0] mn;
        for (int p = 0; p < 11; p++) begin
            wait_idle();
            idle_on = (p < 8) && (p % 3 != 1);
            en   = ($urandom_range(0, 7) != 0);
            mode = $urandom_range(0, 3);
            lo   = 16'($urandom_range(0, 8000));
            mn   = 16'($urandom_range(0, 32768));
            if (mode == 0)
                cfg_all(en, RST_HIGH_THR, RST_LOW_THR, RST_MIN_SCALE, RST_MAX_SCALE,
                        RST_DECAY, RST_RECOVERY);
            else if (mode == 1)
                cfg_all(en, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
            else
                cfg_all(en, lo + 16'($urandom_range(0, 3000)), lo,
                        mn, mn + 16'($urandom_range(0, 32767)),
                        16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
            for (int k = 0; k < 150; k++)
                send_req(pick_req());
        end
    endtask

    initial begin
        clear_window();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_passthrough();
        test_default_stepping();
        test_register_extremes();
        test_random_load();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (render_q.size() != 0) begin
            err_cnt++;
            $error("%0d expected results never arrived", render_q.size());
        end
        if (err_cnt == 0)
            $display("dynamic_resolution_scaler verification clean");
        else
            $display("dynamic_resolution_scaler verification failed");
        $finish;
    end

endmodule
